// ===== hw/rtl/alpc_pkg.sv =====
// Package with the constants and types shared by the loop pair counter files.
package alpc_pkg;

    localparam int NUM_ACTIVITIES = 32;
    localparam int COUNT_WIDTH    = 32;
    localparam int CASE_WIDTH     = 32;

    localparam int ACT_W      = 5;
    localparam int CASE_IN_W  = 32;
    localparam int COUNT_OUT_W = 32;
    localparam int DEPTH      = NUM_ACTIVITIES * NUM_ACTIVITIES;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int ACT_CMP_W  = 9;

    localparam logic [ACT_CMP_W-1:0] ACT_LIMIT   = ACT_CMP_W'(NUM_ACTIVITIES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(DEPTH - 1);

    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic              is_read;
        logic              hit;
        logic              pair_ok;
        logic [ACT_W-1:0]  loop_act;
        logic [ACT_W-1:0]  mid_act;
    } t_lookup;

    typedef struct packed {
        logic                   loop_found;
        logic [ACT_W-1:0]       loop_act;
        logic [ACT_W-1:0]       mid_act;
        logic [COUNT_OUT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic busy;
        logic s1_valid;
    } t_store_status;

    function automatic logic pair_valid(logic [ACT_W-1:0] a, logic [ACT_W-1:0] b);
        return (ACT_CMP_W'(a) < ACT_LIMIT) && (ACT_CMP_W'(b) < ACT_LIMIT);
    endfunction

    function automatic logic [ADDR_W-1:0] pair_addr(logic [ACT_W-1:0] a,
                                                    logic [ACT_W-1:0] b);
        return ADDR_W'(32'(a) * NUM_ACTIVITIES + 32'(b));
    endfunction

endpackage

// ===== hw/rtl/alpc_if.sv =====
// Handshake interfaces for the request and result channels.
interface alpc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [alpc_pkg::CASE_IN_W-1:0] case_id;
    logic [alpc_pkg::ACT_W-1:0]    activity;
    logic [alpc_pkg::ACT_W-1:0]    query_middle;

    modport source (output valid, req_type, case_id, activity, query_middle, input ready);
    modport sink (input valid, req_type, case_id, activity, query_middle, output ready);
endinterface

interface alpc_res_if;
    logic                            valid;
    logic                            ready;
    logic                            loop_found;
    logic [alpc_pkg::ACT_W-1:0]      loop_activity;
    logic [alpc_pkg::ACT_W-1:0]      middle_activity;
    logic [alpc_pkg::COUNT_OUT_W-1:0] pair_count;

    modport source (output valid, loop_found, loop_activity, middle_activity, pair_count,
                    input ready);
    modport sink (input valid, loop_found, loop_activity, middle_activity, pair_count,
                  output ready);
endinterface

// ===== hw/rtl/alpc_history.sv =====
// Event history of the last two logged events and the loop detection on it.
module alpc_history (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_req_type,
    input  logic [alpc_pkg::CASE_IN_W-1:0] i_case_id,
    input  logic [alpc_pkg::ACT_W-1:0]     i_activity,
    input  logic [alpc_pkg::ACT_W-1:0]     i_query_middle,
    output alpc_pkg::t_lookup              o_lookup
);
    logic [alpc_pkg::CASE_WIDTH-1:0] r_prev_case, r_older_case, n_case;
    logic [alpc_pkg::ACT_W-1:0]      r_prev_act, r_older_act;
    logic [1:0]                      r_fill;
    logic                            loop_hit;

    assign n_case = alpc_pkg::CASE_WIDTH'(i_case_id);

    assign loop_hit = (r_fill == 2'd2) && (n_case == r_older_case) &&
                      (i_activity == r_older_act) && (i_activity != r_prev_act) &&
                      alpc_pkg::pair_valid(i_activity, r_prev_act);

    always_comb begin
        o_lookup = '0;
        if (i_req_type == alpc_pkg::REQ_READ) begin
            o_lookup.is_read  = 1'b1;
            o_lookup.pair_ok  = alpc_pkg::pair_valid(i_activity, i_query_middle);
            o_lookup.loop_act = i_activity;
            o_lookup.mid_act  = i_query_middle;
        end else begin
            o_lookup.hit      = loop_hit;
            o_lookup.pair_ok  = loop_hit;
            o_lookup.loop_act = loop_hit ? i_activity : '0;
            o_lookup.mid_act  = loop_hit ? r_prev_act : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_case  <= '0;
            r_prev_act   <= '0;
            r_older_case <= '0;
            r_older_act  <= '0;
            r_fill       <= '0;
        end else if (i_accept && i_req_type == alpc_pkg::REQ_EVENT) begin
            r_older_case <= r_prev_case;
            r_older_act  <= r_prev_act;
            r_prev_case  <= n_case;
            r_prev_act   <= i_activity;
            if (r_fill != 2'd2) begin
                r_fill <= r_fill + 2'd1;
            end
        end
    end
endmodule

// ===== hw/rtl/alpc_count_store.sv =====
// Pair counter memory with clearing pass, read stage, forwarding and saturating update.
module alpc_count_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_advance,
    input  alpc_pkg::t_lookup        i_lookup,
    output alpc_pkg::t_store_status  o_status,
    output alpc_pkg::t_result        o_result
);
    logic [alpc_pkg::COUNT_WIDTH-1:0] r_mem [alpc_pkg::DEPTH];
    logic                             r_clearing;
    logic [alpc_pkg::ADDR_W-1:0]      r_clr_addr;
    logic                             r_s1_valid;
    alpc_pkg::t_lookup                r_s1;
    logic [alpc_pkg::ADDR_W-1:0]      r_s1_addr;
    logic [alpc_pkg::COUNT_WIDTH-1:0] r_rd_data;
    logic                             r_fwd;
    logic [alpc_pkg::COUNT_WIDTH-1:0] r_fwd_data;
    logic [alpc_pkg::ADDR_W-1:0]      rd_addr;
    logic [alpc_pkg::COUNT_WIDTH-1:0] cur_count, inc_count;
    logic                             wr_en;

    assign rd_addr   = i_lookup.pair_ok ?
                       alpc_pkg::pair_addr(i_lookup.loop_act, i_lookup.mid_act) : '0;
    assign cur_count = r_fwd ? r_fwd_data : r_rd_data;
    assign inc_count = (cur_count == alpc_pkg::COUNT_MAX) ? cur_count :
                       cur_count + alpc_pkg::COUNT_WIDTH'(1);
    assign wr_en     = i_advance && r_s1.hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + alpc_pkg::ADDR_W'(1);
                if (r_clr_addr == alpc_pkg::LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            r_mem[r_s1_addr] <= inc_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1       <= i_lookup;
            r_s1_addr  <= rd_addr;
            r_rd_data  <= r_mem[rd_addr];
            r_fwd      <= wr_en && (r_s1_addr == rd_addr);
            r_fwd_data <= inc_count;
        end
    end

    always_comb begin
        o_result            = '0;
        o_result.loop_found = r_s1.hit;
        o_result.loop_act   = r_s1.loop_act;
        o_result.mid_act    = r_s1.mid_act;
        if (r_s1.hit) begin
            o_result.count = alpc_pkg::COUNT_OUT_W'(inc_count);
        end else if (r_s1.is_read && r_s1.pair_ok) begin
            o_result.count = alpc_pkg::COUNT_OUT_W'(cur_count);
        end
    end

    assign o_status.busy     = r_clearing;
    assign o_status.s1_valid = r_s1_valid;
endmodule

// ===== hw/rtl/aba_loop_pair_counter.sv =====
// Top level of the length-two loop pair counter.
//
// Requests arrive on i_req: a log event (case, activity) or a read of the
// counter of an (activity, middle activity) pair. Each request gives exactly
// one transaction on o_res, in request order.
// An event that closes a pattern A B A within the same case of A increments
// the saturating counter of the pair (A, B) and reports the new count.
// An accepted request first reads the counter memory into the read stage;
// when it advances, a hit updates the counter and the output register loads.
// One request is taken in every cycle unless clearing or stalled; a repeated
// pair in the request directly behind is forwarded around the memory write.
// After reset the counter memory is cleared one entry a cycle, all 1024
// entries, with i_req.ready low; the history of events is empty.
// When the receiver holds o_res.ready low, the result stays in the output
// register, the pending request waits in the read stage and i_req.ready
// drops until the output register frees up.
module aba_loop_pair_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alpc_req_if.sink    i_req,
    alpc_res_if.source  o_res
);
    logic                    accept, advance;
    alpc_pkg::t_lookup       lookup;
    alpc_pkg::t_store_status st;
    alpc_pkg::t_result       result;
    logic                    r_out_valid;
    alpc_pkg::t_result       r_out;

    assign advance     = st.s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !st.busy && (!st.s1_valid || advance);
    assign accept      = i_req.valid && i_req.ready;

    alpc_history u_history (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_req.req_type),
        .i_case_id      (i_req.case_id),
        .i_activity     (i_req.activity),
        .i_query_middle (i_req.query_middle),
        .o_lookup       (lookup)
    );

    alpc_count_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_advance (advance),
        .i_lookup  (lookup),
        .o_status  (st),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.loop_found      = r_out.loop_found;
    assign o_res.loop_activity   = r_out.loop_act;
    assign o_res.middle_activity = r_out.mid_act;
    assign o_res.pair_count      = r_out.count;

    a_no_accept_while_clearing: assert property (@(posedge i_clk)
        st.busy |-> !i_req.ready)
        else $error("Request accepted during the clearing pass.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("Result valid right after reset.");

    a_loop_pair_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.loop_found) |-> (o_res.loop_activity != o_res.middle_activity))
        else $error("Loop reported with equal loop and middle activities.");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st.s1_valid && o_res.valid && !o_res.ready) |=> st.s1_valid)
        else $error("Read stage lost a request while the output was stalled.");
endmodule
